// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/hie_pkg.sv -----
// Shared types and constants for the heap insert engine.
`default_nettype none

package hie_pkg;

  localparam int HEAP_DEPTH_DEF = 1024;
  localparam int ID_W           = 32;
  localparam int KEY_W          = 32;
  localparam int CNT_OUT_W      = 11;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/heap_insert_engine.sv -----
// Heap insert engine: min-heap or min-max heap insert over a single entry RAM.
//
//   channel   signals                                  direction
//   item      item_valid, item_stall, start_new, id/key  in
//   result    result_valid, result_stall, root/bottom/  out
//             leftmost id/key, entry_count, was_full
//   config    cfg_wr_en, cfg_wr_data (heap_mode)        in
//
// One word in flight: take and set up the word, open the climb, climb with one RAM read per
// step and end it (after a parent check in min-max mode), then read out the result entries.
// A plain climb to the root at full depth is the longest run; one RAM access per level sets
// it. A full heap skips the climb. The result register frees the engine from the output
// stall; it waits only if the previous result is still held.
// rst is synchronous: heap empty, mode 0; the entry RAM itself is not cleared.
`default_nettype none
`include "assert_macros.svh"

module heap_insert_engine #(
  parameter int HEAP_DEPTH = hie_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic                            cfg_wr_data,
  input  wire logic                            item_valid,
  output      logic                            item_stall,
  input  wire logic                            start_new,
  input  wire logic signed [hie_pkg::ID_W-1:0] item_id,
  input  wire logic signed [hie_pkg::KEY_W-1:0] item_key,
  output      logic                            result_valid,
  input  wire logic                            result_stall,
  output      logic signed [hie_pkg::ID_W-1:0] root_id,
  output      logic signed [hie_pkg::KEY_W-1:0] root_key,
  output      logic signed [hie_pkg::ID_W-1:0] bottom_id,
  output      logic signed [hie_pkg::KEY_W-1:0] bottom_key,
  output      logic signed [hie_pkg::ID_W-1:0] leftmost_id,
  output      logic signed [hie_pkg::KEY_W-1:0] leftmost_key,
  output      logic [hie_pkg::CNT_OUT_W-1:0]   entry_count,
  output      logic                            was_full
);
  import hie_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH + 1);

  function automatic logic [AW-1:0] odd_mask();
    logic [AW-1:0] m;
    m = '0;
    for (int i = 0; i < AW; i++) begin
      m[i] = i[0];
    end
    return m;
  endfunction

  localparam logic [AW-1:0] ODD_MASK = odd_mask();
  localparam logic [AW-1:0] DEPTH_A  = AW'(HEAP_DEPTH);
  localparam logic [AW-1:0] ROOT_POS = AW'(1);

  function automatic logic [AW-1:0] top_bit(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    r = '0;
    for (int i = 0; i < AW; i++) begin
      if (v[i]) begin
        r    = '0;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_START     = 9'b000000010,
    S_PAR_CMP   = 9'b000000100,
    S_CLIMB_RD  = 9'b000001000,
    S_CLIMB_CMP = 9'b000010000,
    S_OUT_ROOT  = 9'b000100000,
    S_OUT_BOT   = 9'b001000000,
    S_OUT_LEFT  = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t        state, state_next;
  logic          heap_mode;
  logic [AW-1:0] count;
  logic          full;
  entry_t        x;
  logic [AW-1:0] pos, pos_next;
  logic          grand, grand_next;
  logic          dir_max, dir_max_next;
  entry_t        root, bottom;

  // entry RAM, position 0 unused
  entry_t        mem [0:HEAP_DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rdata;

  logic          acc, load;
  logic [AW-1:0] cnt_base, anc, up, left_pos;
  logic          lvl_even, x_lt_p, p_lt_x, swap;
  logic [AW+CNT_OUT_W-1:0] cnt_ext;

  assign acc        = item_valid && (state == S_IDLE);
  assign item_stall = (state != S_IDLE);
  assign load       = (state == S_DONE) && (!result_valid || !result_stall);

  assign cnt_base = start_new ? '0 : count;
  assign anc      = grand ? (pos >> 2) : (pos >> 1);
  assign up       = grand ? (pos >> 4) : (pos >> 2);
  assign left_pos = top_bit(count);
  // root sits on level 0; even levels are min levels
  assign lvl_even = ((left_pos & ODD_MASK) == '0);
  assign x_lt_p   = $signed(x.key) < $signed(rdata.key);
  assign p_lt_x   = $signed(rdata.key) < $signed(x.key);

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    grand_next   = grand;
    dir_max_next = dir_max;
    mem_we       = 1'b0;
    wr_addr      = pos;
    wr_data      = x;
    mem_re       = 1'b0;
    rd_addr      = anc;
    swap         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc) state_next = S_START;
      end
      S_START: begin
        pos_next = count;
        if (full) begin
          state_next = S_OUT_ROOT;
        end else if (heap_mode && (count != ROOT_POS)) begin
          mem_re     = 1'b1;
          rd_addr    = count >> 1;
          state_next = S_PAR_CMP;
        end else begin
          grand_next   = 1'b0;
          dir_max_next = 1'b0;
          state_next   = S_CLIMB_RD;
        end
      end
      S_PAR_CMP: begin
        swap         = lvl_even ? p_lt_x : x_lt_p;
        dir_max_next = (lvl_even == swap);
        grand_next   = 1'b1;
        if (swap) begin
          mem_we   = 1'b1;
          wr_data  = rdata;
          pos_next = pos >> 1;
        end
        state_next = S_CLIMB_RD;
      end
      S_CLIMB_RD: begin
        if (anc == '0) begin
          mem_we     = 1'b1;
          state_next = S_OUT_ROOT;
        end else begin
          mem_re     = 1'b1;
          state_next = S_CLIMB_CMP;
        end
      end
      S_CLIMB_CMP: begin
        swap = dir_max ? p_lt_x : x_lt_p;
        if (swap) begin
          mem_we   = 1'b1;
          wr_data  = rdata;
          pos_next = anc;
          if (up != '0) begin
            mem_re  = 1'b1;
            rd_addr = up;
          end else begin
            state_next = S_CLIMB_RD;
          end
        end else begin
          mem_we     = 1'b1;
          state_next = S_OUT_ROOT;
        end
      end
      S_OUT_ROOT: begin
        mem_re     = 1'b1;
        rd_addr    = ROOT_POS;
        state_next = S_OUT_BOT;
      end
      S_OUT_BOT: begin
        mem_re     = 1'b1;
        rd_addr    = count;
        state_next = S_OUT_LEFT;
      end
      S_OUT_LEFT: begin
        mem_re     = 1'b1;
        rd_addr    = left_pos;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      heap_mode <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) heap_mode <= cfg_wr_data;
      if (acc) begin
        if (cnt_base == DEPTH_A) begin
          count <= cnt_base;
        end else begin
          count <= cnt_base + ROOT_POS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    grand   <= grand_next;
    dir_max <= dir_max_next;
    if (acc) begin
      x.id  <= item_id;
      x.key <= item_key;
      full  <= (cnt_base == DEPTH_A);
    end
    if (state == S_OUT_BOT)  root   <= rdata;
    if (state == S_OUT_LEFT) bottom <= rdata;
  end

  // result register
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      root_id      <= root.id;
      root_key     <= root.key;
      bottom_id    <= bottom.id;
      bottom_key   <= bottom.key;
      leftmost_id  <= rdata.id;
      leftmost_key <= rdata.key;
      entry_count  <= cnt_ext[CNT_OUT_W-1:0];
      was_full     <= full;
    end
  end

  `ASSERT_CLK(a_count_bound, count <= DEPTH_A, "heap count beyond depth")
  `ASSERT_CLK(a_wr_in_heap, mem_we |-> (wr_addr != '0 && wr_addr <= count),
              "write outside occupied positions")
  `ASSERT_CLK(a_no_rw_clash, (mem_we && mem_re) |-> (wr_addr != rd_addr),
              "read and write to one entry in the same cycle")
  `ASSERT_CLK(a_full_count, (load && full) |-> (count == DEPTH_A),
              "full flag without a full heap")
  `ASSERT_CLK_ALWAYS(a_rst_idle, rst |=> (state == S_IDLE && !result_valid),
                     "engine busy after reset")

endmodule

`default_nettype wire

// ----- dv/heap_insert_engine_tb.sv -----
// Testbench for the heap insert engine: directed and random inserts checked against a heap predictor.
`timescale 1ns / 1ps

module heap_insert_engine_tb;
  import hie_pkg::*;

  localparam int DEPTH     = HEAP_DEPTH_DEF;
  localparam int HOLD_LEN  = 400;
  localparam bit MODE_PLAIN  = 1'b0;
  localparam bit MODE_MINMAX = 1'b1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic   start;
    entry_t e;
  } insert_req_t;

  typedef struct {
    logic [31:0]          root_id, root_key;
    logic [31:0]          bottom_id, bottom_key;
    logic [31:0]          leftmost_id, leftmost_key;
    logic [CNT_OUT_W-1:0] count;
    logic                 full;
  } heap_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic start_new = 1'b0;
  logic [31:0] item_id = '0;
  logic [31:0] item_key = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [31:0] root_id, root_key, bottom_id, bottom_key, leftmost_id, leftmost_key;
  logic [CNT_OUT_W-1:0] entry_count;
  logic was_full;

  insert_req_t insert_q[$];
  heap_view_t  view_q[$];
  entry_t      heap_mem[1:DEPTH];
  int          heap_used = 0;
  bit          heap_mode = MODE_PLAIN;
  idle_mode_t  idle_mode = IDLE_NONE;
  int          fail_count = 0;
  bit          took_word = 1'b0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  always #4 clk = ~clk;

  heap_insert_engine i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .start_new    (start_new),
    .item_id      (item_id),
    .item_key     (item_key),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .root_id      (root_id),
    .root_key     (root_key),
    .bottom_id    (bottom_id),
    .bottom_key   (bottom_key),
    .leftmost_id  (leftmost_id),
    .leftmost_key (leftmost_key),
    .entry_count  (entry_count),
    .was_full     (was_full)
  );

  // ---------------- predictor ----------------

  function automatic bit key_lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void sift_plain(int p, entry_t x);
    while (p != 1 && key_lt(x.key, heap_mem[p/2].key)) begin
      heap_mem[p] = heap_mem[p/2];
      p = p / 2;
    end
    heap_mem[p] = x;
  endfunction

  // climb through grandparents of the same level kind
  function automatic void sift_grand(int p, entry_t x, bit to_max);
    while (p >= 4 && (to_max ? key_lt(heap_mem[p/4].key, x.key)
                             : key_lt(x.key, heap_mem[p/4].key))) begin
      heap_mem[p] = heap_mem[p/4];
      p = p / 4;
    end
    heap_mem[p] = x;
  endfunction

  function automatic void sift_minmax(int p, entry_t x);
    int  lvl;
    int  q;
    bit  max_lvl;
    if (p == 1) begin
      heap_mem[1] = x;
      return;
    end
    lvl = 0;
    q = p;
    while (q > 1) begin
      q = q / 2;
      lvl++;
    end
    max_lvl = lvl[0];
    if (!max_lvl && key_lt(heap_mem[p/2].key, x.key)) begin
      heap_mem[p] = heap_mem[p/2];
      sift_grand(p / 2, x, 1'b1);
    end else if (max_lvl && key_lt(x.key, heap_mem[p/2].key)) begin
      heap_mem[p] = heap_mem[p/2];
      sift_grand(p / 2, x, 1'b0);
    end else begin
      sift_grand(p, x, max_lvl);
    end
  endfunction

  function automatic heap_view_t heap_insert(insert_req_t r);
    heap_view_t v;
    int         left;
    v.full = 1'b0;
    if (r.start) heap_used = 0;
    if (heap_used >= DEPTH) begin
      v.full = 1'b1;
    end else begin
      heap_used++;
      if (heap_mode == MODE_MINMAX) sift_minmax(heap_used, r.e);
      else sift_plain(heap_used, r.e);
    end
    left = 1;
    while (left * 2 <= heap_used) left = left * 2;
    v.root_id      = heap_mem[1].id;
    v.root_key     = heap_mem[1].key;
    v.bottom_id    = heap_mem[heap_used].id;
    v.bottom_key   = heap_mem[heap_used].key;
    v.leftmost_id  = heap_mem[left].id;
    v.leftmost_key = heap_mem[left].key;
    v.count        = heap_used[CNT_OUT_W-1:0];
    return v;
  endfunction

  // ---------------- driver ----------------

  function automatic int send_idle_pct();
    case (idle_mode)
      IDLE_SEND: return 64;
      IDLE_BOTH: return 26;
      default:   return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (idle_mode)
      IDLE_RECV: return 64;
      IDLE_BOTH: return 26;
      default:   return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    took_word = !rst && item_valid && !item_stall;
    if (took_word) view_q.insert(view_q.size(), heap_insert(insert_q.pop_front()));
  end

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || took_word) begin
      if (insert_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        item_valid <= 1'b1;
        start_new  <= insert_q[0].start;
        item_id    <= insert_q[0].e.id;
        item_key   <= insert_q[0].e.key;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_LEN;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= $urandom_range(99) < recv_idle_pct();
    end
  end

  // ---------------- monitor ----------------

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    heap_view_t v;
    if (!rst && result_valid && !result_stall) begin
      if (view_q.size() == 0) begin
        $error("result word with no prediction pending");
        fail_count++;
      end else begin
        v = view_q.pop_front();
        check_field("root_id", v.root_id, root_id);
        check_field("root_key", v.root_key, root_key);
        check_field("bottom_id", v.bottom_id, bottom_id);
        check_field("bottom_key", v.bottom_key, bottom_key);
        check_field("leftmost_id", v.leftmost_id, leftmost_id);
        check_field("leftmost_key", v.leftmost_key, leftmost_key);
        check_field("entry_count", 32'(v.count), 32'(entry_count));
        check_field("was_full", 32'(v.full), 32'(was_full));
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic push_item(bit s, logic [31:0] id, logic [31:0] key);
    insert_req_t r;
    r.start  = s;
    r.e.id   = id;
    r.e.key  = key;
    insert_q.insert(insert_q.size(), r);
  endtask

  task automatic drain();
    while (insert_q.size() != 0 || view_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    heap_mode = m;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      6, 7, 8: return 32'($urandom_range(16)) - 32'd8;   // dense, plenty of ties
      9: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // plain heap: extremes, ties, sift to root
    set_mode(MODE_PLAIN);
    push_item(1, 32'h7fff_ffff, 32'h0000_0000);
    push_item(0, 32'h8000_0000, 32'h7fff_ffff);
    push_item(0, 32'h0000_0000, 32'h8000_0000);
    push_item(0, 32'hffff_ffff, 32'h8000_0000);
    push_item(0, 32'h0000_0005, 32'hffff_ffff);
    push_item(0, 32'h0000_0006, 32'd5);
    push_item(0, 32'h0000_0007, 32'd5);
    drain();

    // min-max: parent swaps on both level kinds, grandparent climbs, early stop
    set_mode(MODE_MINMAX);
    push_item(1, 32'd1, 32'd10);
    push_item(0, 32'd2, 32'd20);
    push_item(0, 32'd3, 32'd5);
    push_item(0, 32'd4, 32'd30);
    push_item(0, 32'd5, 32'd1);
    push_item(0, 32'd6, 32'd7);
    push_item(0, 32'd7, 32'd40);
    push_item(0, 32'd8, 32'd25);
    push_item(0, 32'd9, 32'd100);
    push_item(0, 32'h8000_0000, 32'h8000_0000);
    drain();

    // switch back mid-build, store left as it is
    set_mode(MODE_PLAIN);
    push_item(0, 32'h7fff_ffff, 32'd0);
    push_item(0, 32'hffff_ffff, 32'h7fff_ffff);
    push_item(0, 32'h0000_0000, 32'd3);
    drain();

    for (int im = IDLE_NONE; im <= IDLE_BOTH; im++) begin
      idle_mode = idle_mode_t'(im);
      for (int n = 0; n < 25; n++) push_item($urandom_range(29) == 0, $urandom, pick_key());
      drain();
    end

    // min-max build run past full depth, across all idle modes
    set_mode(MODE_MINMAX);
    for (int im = IDLE_NONE; im <= IDLE_BOTH; im++) begin
      idle_mode = idle_mode_t'(im);
      if (im == IDLE_NONE) hold_req++;
      for (int n = 0; n < 262; n++) push_item(im == IDLE_NONE && n == 0, $urandom, pick_key());
      drain();
    end

    // full heap in plain mode, then restart
    set_mode(MODE_PLAIN);
    idle_mode = IDLE_BOTH;
    for (int n = 0; n < 12; n++) push_item(n == 4, $urandom, pick_key());
    drain();

    repeat (40) @(posedge clk);
    if (fail_count == 0 && view_q.size() == 0)
      $display("heap_insert_engine: match");
    else
      $display("heap_insert_engine: mismatch");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("heap_insert_engine: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hie_pkg.sv
rtl/heap_insert_engine.sv
dv/heap_insert_engine_tb.sv
